// ===== rtl/core/psh_pkg.sv =====
// ----------------------------------------------------------------------------
// psh_pkg: shared definitions for the per-station history buffer
//
// Field widths, result status codes, action codes, the stored record layout
// and the status bundle returned by the station key scan.
// ----------------------------------------------------------------------------
package psh_pkg;

    // Field widths fixed by the stream format.
    localparam int ADDR_W      = 48;
    localparam int FRAC_W      = 8;
    localparam int AMOUNT_W    = 5;
    localparam int DEPTH_CFG_W = 5;
    localparam int STATUS_W    = 2;
    localparam int IN_DATA_W   = 88;
    localparam int OUT_DATA_W  = 32;

    // A read never returns more records than this.
    localparam int RESULT_CAP  = 16;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_RECORD   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_DATA  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd3;

    // Action codes carried in tuser.
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    // One stored history record, hidden node fraction in the top byte.
    typedef struct packed {
        logic [FRAC_W-1:0] hn_frac;
        logic [FRAC_W-1:0] ir_frac;
        logic [FRAC_W-1:0] nw_frac;
        logic [FRAC_W-1:0] ws_frac;
    } record_t;

    // Outcome of one key scan, valid in the cycle that done is high.
    typedef struct packed {
        logic done;
        logic found;
        logic free_found;
    } scan_status_t;

endpackage

// ===== rtl/core/psh_key_scan.sv =====
// ----------------------------------------------------------------------------
// psh_key_scan: station key table with a one-compare-per-cycle search
//
// Holds the station keys in a memory and one valid bit per station. A scan
// walks the table one entry a cycle with a single 48-bit comparator, stops on
// the first match and remembers the lowest free slot seen on the way.
// ----------------------------------------------------------------------------
module psh_key_scan #(
    parameter int STATIONS = 16,
    parameter int IDX_W    = (STATIONS > 1) ? $clog2(STATIONS) : 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [psh_pkg::ADDR_W-1:0]  key,
    input  logic                        wr_en,
    input  logic [IDX_W-1:0]            wr_idx,
    input  logic [psh_pkg::ADDR_W-1:0]  wr_key,
    output psh_pkg::scan_status_t       scan_status,
    output logic [IDX_W-1:0]            match_idx,
    output logic [IDX_W-1:0]            free_idx
);
    import psh_pkg::*;

    localparam logic SC_IDLE = 1'b0;
    localparam logic SC_SCAN = 1'b1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATIONS - 1);

    logic [ADDR_W-1:0] key_mem [0:STATIONS-1];
    logic [ADDR_W-1:0] key_rd_reg;
    logic [IDX_W-1:0]  key_raddr;

    logic                state_reg, state_next;
    logic [STATIONS-1:0] valid_reg;
    logic [IDX_W-1:0]    cmp_reg, cmp_next;
    logic [ADDR_W-1:0]   key_reg, key_next;
    logic                free_found_reg, free_found_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;

    logic hit;
    logic slot_free;
    logic at_end;

    // The entry under compare was read in the previous cycle.
    assign hit       = valid_reg[cmp_reg] && (key_rd_reg == key_reg);
    assign slot_free = !valid_reg[cmp_reg];
    assign at_end    = (cmp_reg == LAST_IDX);

    // Read one entry ahead of the comparator.
    assign key_raddr = (state_reg == SC_SCAN && !at_end) ? cmp_reg + 1'b1 : '0;

    // Key memory: written on allocation, read every cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_idx] <= wr_key;
        end
        key_rd_reg <= key_mem[key_raddr];
    end

    // Scan sequencer.
    always_comb begin
        state_next      = state_reg;
        cmp_next        = cmp_reg;
        key_next        = key_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        scan_status     = '0;
        unique case (state_reg)
            SC_IDLE: begin
                if (start) begin
                    state_next      = SC_SCAN;
                    cmp_next        = '0;
                    key_next        = key;
                    free_found_next = 1'b0;
                end
            end
            SC_SCAN: begin
                if (slot_free && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_idx_next   = cmp_reg;
                end
                if (hit || at_end) begin
                    state_next             = SC_IDLE;
                    scan_status.done       = 1'b1;
                    scan_status.found      = hit;
                    scan_status.free_found = free_found_reg || slot_free;
                end else begin
                    cmp_next = cmp_reg + 1'b1;
                end
            end
            default: begin
                state_next = SC_IDLE;
            end
        endcase
    end

    assign match_idx = cmp_reg;
    assign free_idx  = free_found_reg ? free_idx_reg : cmp_reg;

    // Control state is reset; valid bits mark allocated stations.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SC_IDLE;
            valid_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (wr_en) begin
                valid_reg[wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmp_reg        <= cmp_next;
        key_reg        <= key_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
    end

endmodule

// ===== rtl/core/per_station_history_buffer.sv =====
// ----------------------------------------------------------------------------
// per_station_history_buffer: keyed newest-first loss history per station
//
// Keeps a table of station addresses, each with a ring of loss-fraction
// records. Inserts push a record; reads return the newest records first.
// ----------------------------------------------------------------------------
// One item is handled at a time. An insert or a read first searches the
// station table with one key compare per cycle, stopping on a match or after
// the last slot. After the search, the station's count and ring pointer are
// fetched (ST_META) and the item executes (ST_EXEC), waiting there until the
// output register is free. A read that returns records then passes through
// ST_RD_ISSUE (address) and ST_RD_DATA (registered data) on the history
// memory port for each record. A new input transfer is taken as soon as the
// previous item has handed its last result to the output register, even if
// that result is still waiting there. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module per_station_history_buffer #(
    parameter int STATIONS    = 16,
    parameter int HISTORY_MAX = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration: history depth.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [psh_pkg::DEPTH_CFG_W-1:0]   cfg_data,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [47:0] station address, [55:48] hidden node fraction,
    // [63:56] in-range fraction, [71:64] non-wifi fraction,
    // [79:72] weak signal fraction, [84:80] read amount, [87:85] zero
    input  logic [psh_pkg::IN_DATA_W-1:0]     s_tdata,
    // [0] action
    input  logic [0:0]                        s_tuser,
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] hidden node, [15:8] in-range,
    // [23:16] non-wifi, [31:24] weak signal
    output logic [psh_pkg::OUT_DATA_W-1:0]    m_tdata,
    // [1:0] status
    output logic [psh_pkg::STATUS_W-1:0]      m_tuser,
    output logic                              m_tlast
);
    import psh_pkg::*;

    localparam int SW = (STATIONS > 1) ? $clog2(STATIONS) : 1;
    localparam int PW = (HISTORY_MAX > 1) ? $clog2(HISTORY_MAX) : 1;
    localparam int CW = $clog2(HISTORY_MAX + 1);
    localparam int MW = (CW > AMOUNT_W) ? CW : AMOUNT_W;
    localparam int HIST_DEPTH = STATIONS * (2 ** PW);
    localparam logic [PW-1:0] PTR_LAST = PW'(HISTORY_MAX - 1);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN     = 3'd1;
    localparam logic [2:0] ST_META     = 3'd2;
    localparam logic [2:0] ST_EXEC     = 3'd3;
    localparam logic [2:0] ST_RD_ISSUE = 3'd4;
    localparam logic [2:0] ST_RD_DATA  = 3'd5;

    typedef struct packed {
        logic [CW-1:0] count;
        logic [PW-1:0] newest;
    } meta_t;

    // Registers.
    logic [2:0]             state_reg, state_next;
    logic [DEPTH_CFG_W-1:0] depth_cfg_reg;
    logic                   action_reg, action_next;
    record_t                rec_reg, rec_next;
    logic [AMOUNT_W-1:0]    amount_reg, amount_next;
    logic [SW-1:0]          sta_reg, sta_next;
    logic                   found_reg, found_next;
    logic                   free_ok_reg, free_ok_next;
    logic [AMOUNT_W-1:0]    rem_reg, rem_next;
    logic [PW-1:0]          rd_ptr_reg, rd_ptr_next;
    logic                   m_tvalid_reg;
    logic [OUT_DATA_W-1:0]  m_tdata_reg;
    logic [STATUS_W-1:0]    m_tuser_reg;
    logic                   m_tlast_reg;

    // Memories.
    meta_t   meta_mem [0:STATIONS-1];
    meta_t   meta_rd_reg;
    meta_t   meta_wdata;
    logic    meta_we;
    record_t hist_mem [0:HIST_DEPTH-1];
    record_t hist_rd_reg;
    logic    hist_we;
    logic [SW+PW-1:0] hist_waddr, hist_raddr;

    // Scan interface.
    scan_status_t    scan_st;
    logic [SW-1:0]   match_idx, free_idx;
    logic            alloc_en;
    logic [ADDR_W-1:0] key_in;
    logic [ADDR_W-1:0] key_hold_reg;
    logic            in_xfer;

    // Execution helpers.
    logic [CW-1:0]    depth_eff;
    logic [CW-1:0]    base_count;
    logic [PW-1:0]    base_ptr;
    logic [PW-1:0]    new_ptr;
    logic [CW-1:0]    new_count;
    logic [MW-1:0]    n_min;
    logic [AMOUNT_W-1:0] n_rd;
    logic             out_free;
    logic             out_load;
    logic [STATUS_W-1:0] out_status;
    record_t          out_rec;
    logic             out_last;

    assign in_xfer  = s_tvalid && s_tready;
    assign key_in   = s_tdata[ADDR_W-1:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free = !m_tvalid_reg || m_tready;

    // Station key table and search.
    psh_key_scan #(
        .STATIONS (STATIONS),
        .IDX_W    (SW)
    ) u_key_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (in_xfer),
        .key         (key_in),
        .wr_en       (alloc_en),
        .wr_idx      (sta_reg),
        .wr_key      (key_hold_reg),
        .scan_status (scan_st),
        .match_idx   (match_idx),
        .free_idx    (free_idx)
    );

    // Key of the item in progress, written into the table on allocation.
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            key_hold_reg <= key_in;
        end
    end

    // Effective depth: zero acts as one, large values clamp to the ring size.
    always_comb begin
        if (depth_cfg_reg == '0) begin
            depth_eff = CW'(1);
        end else if (MW'(depth_cfg_reg) > MW'(HISTORY_MAX)) begin
            depth_eff = CW'(HISTORY_MAX);
        end else begin
            depth_eff = CW'(depth_cfg_reg);
        end
    end

    // Insert arithmetic: a new station starts from an empty ring.
    assign base_count = found_reg ? meta_rd_reg.count  : '0;
    assign base_ptr   = found_reg ? meta_rd_reg.newest : '0;
    assign new_ptr    = (base_ptr == PTR_LAST) ? '0 : base_ptr + 1'b1;
    assign new_count  = (base_count < depth_eff) ? base_count + 1'b1 : base_count;

    // Records a read returns: min(amount, stored, depth, cap).
    always_comb begin
        n_min = MW'(amount_reg);
        if (MW'(meta_rd_reg.count) < n_min) begin
            n_min = MW'(meta_rd_reg.count);
        end
        if (MW'(depth_eff) < n_min) begin
            n_min = MW'(depth_eff);
        end
        if (MW'(RESULT_CAP) < n_min) begin
            n_min = MW'(RESULT_CAP);
        end
        n_rd = AMOUNT_W'(n_min);
    end

    assign hist_waddr = {sta_reg, new_ptr};
    assign hist_raddr = {sta_reg, rd_ptr_reg};
    assign meta_wdata = '{count: new_count, newest: new_ptr};

    // Main sequencer.
    always_comb begin
        state_next   = state_reg;
        action_next  = action_reg;
        rec_next     = rec_reg;
        amount_next  = amount_reg;
        sta_next     = sta_reg;
        found_next   = found_reg;
        free_ok_next = free_ok_reg;
        rem_next     = rem_reg;
        rd_ptr_next  = rd_ptr_reg;
        alloc_en     = 1'b0;
        meta_we      = 1'b0;
        hist_we      = 1'b0;
        out_load     = 1'b0;
        out_status   = STAT_INSERTED;
        out_rec      = '0;
        out_last     = 1'b1;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next  = ST_SCAN;
                    action_next = s_tuser[0];
                    rec_next    = '{hn_frac: s_tdata[55:48], ir_frac: s_tdata[63:56],
                                    nw_frac: s_tdata[71:64], ws_frac: s_tdata[79:72]};
                    amount_next = s_tdata[84:80];
                end
            end
            ST_SCAN: begin
                if (scan_st.done) begin
                    state_next   = ST_META;
                    found_next   = scan_st.found;
                    free_ok_next = scan_st.free_found;
                    sta_next     = scan_st.found ? match_idx : free_idx;
                end
            end
            ST_META: begin
                // Metadata read of the chosen station is issued this cycle.
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (action_reg == ACT_INSERT) begin
                        if (found_reg || free_ok_reg) begin
                            out_status = STAT_INSERTED;
                            hist_we    = 1'b1;
                            meta_we    = 1'b1;
                            alloc_en   = !found_reg;
                        end else begin
                            out_status = STAT_FULL;
                        end
                    end else if (!found_reg || n_rd == '0) begin
                        out_status = STAT_NO_DATA;
                    end else begin
                        // Records follow; nothing is shown yet.
                        out_load    = 1'b0;
                        state_next  = ST_RD_ISSUE;
                        rem_next    = n_rd;
                        rd_ptr_next = meta_rd_reg.newest;
                    end
                end
            end
            ST_RD_ISSUE: begin
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    out_status  = STAT_RECORD;
                    out_rec     = hist_rd_reg;
                    out_last    = (rem_reg == AMOUNT_W'(1));
                    rem_next    = rem_reg - 1'b1;
                    rd_ptr_next = (rd_ptr_reg == '0) ? PTR_LAST : rd_ptr_reg - 1'b1;
                    state_next  = (rem_reg == AMOUNT_W'(1)) ? ST_IDLE : ST_RD_ISSUE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Per-station count and newest pointer.
    always_ff @(posedge aclk) begin
        if (meta_we) begin
            meta_mem[sta_reg] <= meta_wdata;
        end
        meta_rd_reg <= meta_mem[sta_reg];
    end

    // History ring storage, one ring per station.
    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[hist_waddr] <= rec_reg;
        end
        hist_rd_reg <= hist_mem[hist_raddr];
    end

    // Control registers and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            depth_cfg_reg <= DEPTH_CFG_W'(16);
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                depth_cfg_reg <= cfg_data;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Item payload and output register.
    always_ff @(posedge aclk) begin
        action_reg  <= action_next;
        rec_reg     <= rec_next;
        amount_reg  <= amount_next;
        sta_reg     <= sta_next;
        found_reg   <= found_next;
        free_ok_reg <= free_ok_next;
        rem_reg     <= rem_next;
        rd_ptr_reg  <= rd_ptr_next;
        if (out_load) begin
            m_tdata_reg <= {out_rec.ws_frac, out_rec.nw_frac,
                            out_rec.ir_frac, out_rec.hn_frac};
            m_tuser_reg <= out_status;
            m_tlast_reg <= out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
